FILE: design/cppd_pkg.sv
// Package of shared widths, constants, tables and unit request types for the duty controller.
`default_nettype none

package cppd_pkg;

    // Duty word and accumulator formats.
    localparam int DUTY_BITS     = 32;
    localparam int ACC_FRAC_BITS = 32;
    localparam int ACC_W         = ACC_FRAC_BITS + 8;
    localparam int TERM_SHIFT    = 50 - ACC_FRAC_BITS;

    // Field widths.
    localparam int VOLT_W     = 16;
    localparam int AMP_W      = 16;
    localparam int ERR_W      = 18;
    localparam int SP_W       = 16;
    localparam int PCT_W      = 7;
    localparam int GAIN_W     = 32;
    localparam int OUT_DUTY_W = 32;
    localparam int LIM_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Serial multiplier: operand of the gain, wide enough for the integral sum.
    localparam int MOP_W  = 19;
    localparam int PROD_W = GAIN_W + 1 + MOP_W;
    localparam int MCNT_W = $clog2(MOP_W + 1);
    localparam int SUM_W  = ACC_W + 2;

    // Serial divider, shared by the current target and the duty scaling.
    localparam int TGT_SHIFT  = 12;
    localparam int TGT_DVD_W  = SP_W + TGT_SHIFT;
    localparam int TGT_W      = 15;
    localparam int DUTY_DVD_W = DUTY_BITS + 8;
    localparam int DIV_W      = (TGT_DVD_W > DUTY_DVD_W) ? TGT_DVD_W : DUTY_DVD_W;
    localparam int DVS_W      = 16;
    localparam int ITER_W     = $clog2(DIV_W + 1);

    localparam int PCT_SCALE   = 100;
    localparam int PCT_ENTRIES = 2 ** PCT_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX  = 3'd6;

    // Limit status codes.
    localparam logic [LIM_W-1:0] LIM_NONE = 2'd0;
    localparam logic [LIM_W-1:0] LIM_MAX  = 2'd1;
    localparam logic [LIM_W-1:0] LIM_MIN  = 2'd2;

    // Register reset values.
    localparam logic [SP_W-1:0]   SP_RESET    = 16'd32768;
    localparam logic [GAIN_W-1:0] GP_RESET    = 32'd61847529;
    localparam logic [GAIN_W-1:0] GI_RESET    = 32'd51539608;
    localparam logic [GAIN_W-1:0] GD_RESET    = 32'd111325552;
    localparam logic [VOLT_W-1:0] MINV_RESET  = 16'd2048;
    localparam logic [PCT_W-1:0]  DMIN_RESET  = 7'd1;
    localparam logic [PCT_W-1:0]  DMAX_RESET  = 7'd14;

    localparam logic [63:0] FULL_WIDE = (64'd1 << DUTY_BITS) - 64'd1;

    typedef logic [DUTY_BITS-1:0] duty_t;
    typedef duty_t lim_tab_t [PCT_ENTRIES];

    // Duty fraction of each whole percent, saturated to full scale above 100.
    function automatic lim_tab_t build_lim_tab();
        lim_tab_t    tab;
        logic [63:0] frac;
        for (int p = 0; p < PCT_ENTRIES; p++)
        begin
            frac = (FULL_WIDE * 64'(p)) / 64'(PCT_SCALE);
            tab[p] = (frac > FULL_WIDE) ? FULL_WIDE[DUTY_BITS-1:0] : frac[DUTY_BITS-1:0];
        end
        return tab;
    endfunction

    localparam lim_tab_t LIM_TAB = build_lim_tab();

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] mcand;
        logic [MOP_W-1:0]  mplier;
    } mul_req_t;

endpackage

`default_nettype wire

FILE: design/cppd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module cppd_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cppd_pkg::div_req_t              req,
    output logic                            done,
    output logic [cppd_pkg::DIV_W-1:0]      quot
);

    localparam int DIV_W  = cppd_pkg::DIV_W;
    localparam int DVS_W  = cppd_pkg::DVS_W;
    localparam int ITER_W = cppd_pkg::ITER_W;

    logic [DIV_W-1:0]  dq_reg, dq_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W+1:0]  diff;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dq_reg[DIV_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start)
        begin
            dq_next   = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[DIV_W-2:0], ~diff[DVS_W+1]};
            rem_next = diff[DVS_W+1] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg   <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

`default_nettype wire

FILE: design/cppd_mul.sv
// Signed shift-add multiplier that retires one multiplier bit per cycle.
`default_nettype none

module cppd_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cppd_pkg::mul_req_t               req,
    output logic                             done,
    output logic [cppd_pkg::PROD_W-1:0]      prod
);

    localparam int GAIN_W = cppd_pkg::GAIN_W;
    localparam int MOP_W  = cppd_pkg::MOP_W;
    localparam int MCNT_W = cppd_pkg::MCNT_W;

    logic [GAIN_W:0]   hi_reg, hi_next;
    logic [MOP_W-1:0]  lo_reg, lo_next;
    logic [GAIN_W-1:0] g_reg, g_next;
    logic [MCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              last;
    logic [GAIN_W+1:0] g_ext;
    logic [GAIN_W+1:0] addend;
    logic [GAIN_W+1:0] psum;

    // The sign bit of the multiplier carries negative weight, so its step subtracts.
    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        g_next    = g_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        last      = (cnt_reg == MCNT_W'(1));
        g_ext     = {{2{g_reg[GAIN_W-1]}}, g_reg};
        addend    = '0;
        if (lo_reg[0])
        begin
            addend = last ? ((GAIN_W + 2)'(0) - g_ext) : g_ext;
        end
        psum = {hi_reg[GAIN_W], hi_reg} + addend;
        if (req.start)
        begin
            hi_next   = '0;
            lo_next   = req.mplier;
            g_next    = req.mcand;
            cnt_next  = MCNT_W'(MOP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = psum[GAIN_W+1:1];
            lo_next  = {psum[0], lo_reg[MOP_W-1:1]};
            cnt_next = cnt_reg - MCNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            g_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            g_reg    <= g_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

FILE: design/constant_power_pid_duty_controller.sv
// Top level of the constant-power incremental PID duty controller.
//
//  Channel  | Direction | Signals                                | Transfer when
//  ---------+-----------+----------------------------------------+-------------------------
//  sample   | in        | in_valid, in_ready, func,              | in_valid && in_ready
//           |           | volt_sample, amp_sample                |
//  result   | out       | out_valid, out_ready, duty_word,       | out_valid && out_ready
//           |           | limit_state                            |
//  config   | in        | cfg_write_en, cfg_index, cfg_data      | cfg_write_en
//
// A control sample above the voltage floor runs the bit-serial divider for the current target,
// three 19-bit serial multiplications, and the divider again for the duty scaling when the
// accumulator is positive. Below the floor the target division is skipped, and a clear item
// goes straight to the result without products or divisions. Reset is asynchronous and active
// low; it restores the register defaults and clears the loop history. Samples are taken one at
// a time, and the next one is accepted as soon as the result sits in the output register, even
// while that result stalls.
`default_nettype none

module constant_power_pid_duty_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [cppd_pkg::VOLT_W-1:0]           volt_sample,
    input  logic signed [cppd_pkg::AMP_W-1:0]     amp_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cppd_pkg::OUT_DUTY_W-1:0]       duty_word,
    output logic [cppd_pkg::LIM_W-1:0]            limit_state,
    input  logic                                  cfg_write_en,
    input  logic [cppd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cppd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DUTY_BITS     = cppd_pkg::DUTY_BITS;
    localparam int ACC_FRAC_BITS = cppd_pkg::ACC_FRAC_BITS;
    localparam int ACC_W         = cppd_pkg::ACC_W;
    localparam int SUM_W         = cppd_pkg::SUM_W;
    localparam int PROD_W        = cppd_pkg::PROD_W;
    localparam int MOP_W         = cppd_pkg::MOP_W;
    localparam int ERR_W         = cppd_pkg::ERR_W;
    localparam int AMP_W         = cppd_pkg::AMP_W;
    localparam int DIV_W         = cppd_pkg::DIV_W;
    localparam int ITER_W        = cppd_pkg::ITER_W;
    localparam int TGT_W         = cppd_pkg::TGT_W;
    localparam int TGT_DVD_W     = cppd_pkg::TGT_DVD_W;
    localparam int DUTY_DVD_W    = cppd_pkg::DUTY_DVD_W;
    localparam int DVS_W         = cppd_pkg::DVS_W;
    localparam int OUT_DUTY_W    = cppd_pkg::OUT_DUTY_W;
    localparam int XPROD_W       = ACC_W + DUTY_BITS;

    // Order of the three gain products.
    localparam logic [1:0] PH_PROP  = 2'd0;
    localparam logic [1:0] PH_INTEG = 2'd1;
    localparam logic [1:0] PH_DERIV = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TARGET,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SAT,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_FINISH
    } state_t;

    // Configuration registers.
    logic [cppd_pkg::SP_W-1:0]   sp_reg;
    logic [cppd_pkg::GAIN_W-1:0] gp_reg;
    logic [cppd_pkg::GAIN_W-1:0] gi_reg;
    logic [cppd_pkg::GAIN_W-1:0] gd_reg;
    logic [cppd_pkg::VOLT_W-1:0] minv_reg;
    logic [cppd_pkg::PCT_W-1:0]  dmin_reg;
    logic [cppd_pkg::PCT_W-1:0]  dmax_reg;

    // Sequencer, history and output registers.
    state_t                  state_reg, state_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    func_reg, func_next;
    logic [AMP_W-1:0]        amp_reg, amp_next;
    logic [AMP_W-1:0]        meas_reg, meas_next;
    logic [ERR_W-1:0]        err_reg, err_next;
    logic [ERR_W-1:0]        perr_reg, perr_next;
    logic [AMP_W-1:0]        pm_reg, pm_next;
    logic [AMP_W-1:0]        pm2_reg, pm2_next;
    logic [ACC_W-1:0]        accum_reg, accum_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [DIV_W-1:0]        raw_reg, raw_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DUTY_BITS-1:0]    duty_reg, duty_next;
    logic [cppd_pkg::LIM_W-1:0] lim_reg, lim_next;

    cppd_pkg::div_req_t      div_req;
    cppd_pkg::mul_req_t      mul_req;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quot;
    logic                    mul_done;
    logic [PROD_W-1:0]       mul_prod;

    logic                    in_xfer;
    logic [TGT_W-1:0]        target;
    logic [ERR_W-1:0]        new_err;
    logic [MOP_W-1:0]        pm_x, pm2_x, meas_x, err_x, perr_x;
    logic [MOP_W-1:0]        op_p, op_i, op_d;
    logic signed [PROD_W-1:0] prod_sh;
    logic [SUM_W-1:0]        term;
    logic [ACC_W-1:0]        sat_sum;
    logic                    acc_pos;
    logic [XPROD_W-1:0]      xprod;
    logic [DUTY_DVD_W-1:0]   x_sh;
    logic [DUTY_BITS-1:0]    maxf, minf;
    logic                    out_free;

    cppd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    cppd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= cppd_pkg::SP_RESET;
            gp_reg   <= cppd_pkg::GP_RESET;
            gi_reg   <= cppd_pkg::GI_RESET;
            gd_reg   <= cppd_pkg::GD_RESET;
            minv_reg <= cppd_pkg::MINV_RESET;
            dmin_reg <= cppd_pkg::DMIN_RESET;
            dmax_reg <= cppd_pkg::DMAX_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                cppd_pkg::CFG_SETPOINT:   sp_reg   <= cfg_data[cppd_pkg::SP_W-1:0];
                cppd_pkg::CFG_GAIN_PROP:  gp_reg   <= cfg_data[cppd_pkg::GAIN_W-1:0];
                cppd_pkg::CFG_GAIN_INTEG: gi_reg   <= cfg_data[cppd_pkg::GAIN_W-1:0];
                cppd_pkg::CFG_GAIN_DERIV: gd_reg   <= cfg_data[cppd_pkg::GAIN_W-1:0];
                cppd_pkg::CFG_MIN_VOLT:   minv_reg <= cfg_data[cppd_pkg::VOLT_W-1:0];
                cppd_pkg::CFG_DUTY_MIN:   dmin_reg <= cfg_data[cppd_pkg::PCT_W-1:0];
                cppd_pkg::CFG_DUTY_MAX:   dmax_reg <= cfg_data[cppd_pkg::PCT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The current target saturates to the positive Q5.10 range. A zero divisor gives an
    // all-ones quotient, which lands on the same saturated value.
    assign target  = (|div_quot[DIV_W-1:TGT_W]) ? {TGT_W{1'b1}} : div_quot[TGT_W-1:0];
    assign new_err = {{(ERR_W - TGT_W){1'b0}}, target}
                   - {{(ERR_W - AMP_W){amp_reg[AMP_W-1]}}, amp_reg};

    // Operands of the three products, formed from the history in 19-bit signed form.
    assign pm_x   = {{(MOP_W - AMP_W){pm_reg[AMP_W-1]}}, pm_reg};
    assign pm2_x  = {{(MOP_W - AMP_W){pm2_reg[AMP_W-1]}}, pm2_reg};
    assign meas_x = {{(MOP_W - AMP_W){meas_reg[AMP_W-1]}}, meas_reg};
    assign err_x  = {{(MOP_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign perr_x = {{(MOP_W - ERR_W){perr_reg[ERR_W-1]}}, perr_reg};
    assign op_p   = pm_x - meas_x;
    assign op_i   = err_x + perr_x;
    assign op_d   = {pm_x[MOP_W-2:0], 1'b0} - meas_x - pm2_x;

    // Each product is floored to the accumulator scale on its own before it is summed.
    assign prod_sh = $signed(mul_prod) >>> cppd_pkg::TERM_SHIFT;
    assign term    = prod_sh[SUM_W-1:0];

    // Saturate the sum to the accumulator width when its top bits disagree.
    always_comb
    begin
        if (sum_reg[SUM_W-1:ACC_W-1] == {(SUM_W - ACC_W + 1){sum_reg[SUM_W-1]}})
        begin
            sat_sum = sum_reg[ACC_W-1:0];
        end
        else if (sum_reg[SUM_W-1])
        begin
            sat_sum = {1'b1, {(ACC_W - 1){1'b0}}};
        end
        else
        begin
            sat_sum = {1'b0, {(ACC_W - 1){1'b1}}};
        end
    end

    // Duty scaling: accum * (2^DUTY_BITS - 1), floored to whole percent units, then / 100.
    assign acc_pos = ~accum_reg[ACC_W-1] && (|accum_reg);
    assign xprod   = {accum_reg, {DUTY_BITS{1'b0}}} - XPROD_W'(accum_reg);
    assign x_sh    = xprod[XPROD_W-1:ACC_FRAC_BITS];

    assign maxf     = cppd_pkg::LIM_TAB[dmax_reg];
    assign minf     = cppd_pkg::LIM_TAB[dmin_reg];
    assign out_free = ~out_valid_reg || out_ready;
    assign in_xfer  = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        func_next      = func_reg;
        amp_next       = amp_reg;
        meas_next      = meas_reg;
        err_next       = err_reg;
        perr_next      = perr_reg;
        pm_next        = pm_reg;
        pm2_next       = pm2_reg;
        accum_next     = accum_reg;
        sum_next       = sum_reg;
        raw_next       = raw_reg;
        duty_next      = duty_reg;
        lim_next       = lim_reg;
        out_valid_next = out_valid_reg && ~out_ready;

        div_req          = '0;
        mul_req          = '0;
        mul_req.mcand    = gd_reg;
        mul_req.mplier   = op_d;

        case (phase_reg)
            PH_PROP:
            begin
                mul_req.mcand  = gp_reg;
                mul_req.mplier = op_p;
            end
            PH_INTEG:
            begin
                mul_req.mcand  = gi_reg;
                mul_req.mplier = op_i;
            end
            default:
            begin
                mul_req.mcand  = gd_reg;
                mul_req.mplier = op_d;
            end
        endcase

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next  = func;
                    amp_next   = amp_sample;
                    sum_next   = {{(SUM_W - ACC_W){accum_reg[ACC_W-1]}}, accum_reg};
                    phase_next = PH_PROP;
                    if (func)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (volt_sample >= minv_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.iters    = ITER_W'(TGT_DVD_W);
                        div_req.dividend = DIV_W'({sp_reg, {cppd_pkg::TGT_SHIFT{1'b0}}})
                                           << (DIV_W - TGT_DVD_W);
                        div_req.divisor  = volt_sample;
                        state_next       = ST_TARGET;
                    end
                    else
                    begin
                        // Below the floor the loop sees no measurement and no error.
                        meas_next  = '0;
                        err_next   = '0;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_TARGET:
            begin
                if (div_done)
                begin
                    meas_next  = amp_reg;
                    err_next   = new_err;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                mul_req.start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    sum_next = sum_reg + term;
                    if (phase_reg == PH_DERIV)
                    begin
                        state_next = ST_SAT;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_SAT:
            begin
                accum_next = sat_sum;
                state_next = ST_DUTY_GO;
            end
            ST_DUTY_GO:
            begin
                if (acc_pos)
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ITER_W'(DUTY_DVD_W);
                    div_req.dividend = DIV_W'(x_sh) << (DIV_W - DUTY_DVD_W);
                    div_req.divisor  = DVS_W'(cppd_pkg::PCT_SCALE);
                    state_next       = ST_DUTY_WAIT;
                end
                else
                begin
                    raw_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_DUTY_WAIT:
            begin
                if (div_done)
                begin
                    raw_next   = div_quot;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result and the history update commit together once the output is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (func_reg)
                    begin
                        duty_next  = minf;
                        lim_next   = cppd_pkg::LIM_MIN;
                        accum_next = '0;
                        perr_next  = '0;
                        pm_next    = '0;
                        pm2_next   = '0;
                    end
                    else
                    begin
                        // The maximum is checked first, so it wins when the limits cross.
                        if (raw_reg >= DIV_W'(maxf))
                        begin
                            duty_next  = maxf;
                            lim_next   = cppd_pkg::LIM_MAX;
                            accum_next = ACC_W'(dmax_reg) << ACC_FRAC_BITS;
                        end
                        else if (raw_reg <= DIV_W'(minf))
                        begin
                            duty_next  = minf;
                            lim_next   = cppd_pkg::LIM_MIN;
                            accum_next = ACC_W'(dmin_reg) << ACC_FRAC_BITS;
                        end
                        else
                        begin
                            duty_next = raw_reg[DUTY_BITS-1:0];
                            lim_next  = cppd_pkg::LIM_NONE;
                        end
                        perr_next = err_reg;
                        pm2_next  = pm_reg;
                        pm_next   = meas_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PROP;
            func_reg      <= 1'b0;
            amp_reg       <= '0;
            meas_reg      <= '0;
            err_reg       <= '0;
            perr_reg      <= '0;
            pm_reg        <= '0;
            pm2_reg       <= '0;
            accum_reg     <= '0;
            sum_reg       <= '0;
            raw_reg       <= '0;
            out_valid_reg <= 1'b0;
            duty_reg      <= '0;
            lim_reg       <= cppd_pkg::LIM_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            func_reg      <= func_next;
            amp_reg       <= amp_next;
            meas_reg      <= meas_next;
            err_reg       <= err_next;
            perr_reg      <= perr_next;
            pm_reg        <= pm_next;
            pm2_reg       <= pm2_next;
            accum_reg     <= accum_next;
            sum_reg       <= sum_next;
            raw_reg       <= raw_next;
            out_valid_reg <= out_valid_next;
            duty_reg      <= duty_next;
            lim_reg       <= lim_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign duty_word   = OUT_DUTY_W'(duty_reg);
    assign limit_state = lim_reg;

    // The divider only reports back while the sequencer waits for a quotient.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_TARGET || state_reg == ST_DUTY_WAIT))
        else $error("divider finished outside a quotient wait");

    // The multiplier only reports back while the sequencer waits for a product.
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL_WAIT))
        else $error("multiplier finished outside a product wait");

    // Between samples the accumulator holds zero, a limit, or a value inside the limits.
    a_accum_nonneg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !accum_reg[ACC_W-1])
        else $error("accumulator negative between samples");

    // A result inside the limits lies above the minimum fraction and so is never zero.
    a_free_duty_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && limit_state == cppd_pkg::LIM_NONE) |-> (duty_word != '0))
        else $error("unclamped duty of zero");

endmodule

`default_nettype wire
